// ===== design/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsp_pkg
// Types and constants shared by the WAV stream parser.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // chunk tags, first byte in the top byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    typedef enum logic [1:0] {
        ST_SAMPLE      = 2'd0,
        ST_BAD_HEADER  = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_NO_DATA     = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic signed [31:0] mono_sample;
        t_status            status;
        logic [31:0]        sample_rate;
        logic               last_sample;
    } t_out;

endpackage

// ===== design/wav_stream_parser_mono.sv =====
// ----------------------------------------------------------------------------
// wav_stream_parser_mono
// RIFF/WAVE byte stream parser with a mono down-mix of the PCM and float sample data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one file byte per
//   item; first_byte restarts parsing, last_byte marks the end of the file.
//   Output channel (o_out_valid / i_out_ready / o_out) gives one item per
//   mono sample, or one status item for a bad header, an unsupported format
//   or missing/truncated data.
//   Header and non-final bytes do not use the divider. A byte that completes a
//   frame starts the restoring divider (one quotient bit a cycle over the
//   width of the frame sum), and no further byte is taken until its result
//   is in the output register; the divider sets the rate for frame bytes.
//   Results sit in a single output register; no byte is taken while that
//   register holds an item the receiver has not yet accepted.
//   Reset (synchronous, active low) returns the parser to the header check
//   with all captured fields cleared and the output empty.
//   A stalled receiver holds the output register and, through it, the
//   input: o_in_ready stays low until the waiting item is taken.
// ----------------------------------------------------------------------------
module wav_stream_parser_mono #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wsp_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output wsp_pkg::t_out o_out
);
    import wsp_pkg::*;

    // frame sum width, channel index width, divider step count width
    localparam int SW  = 32 + $clog2(MAX_CHANNELS);
    localparam int CIW = $clog2(MAX_CHANNELS + 1);
    localparam int DCW = $clog2(SW + 1);

    // parse phases
    typedef enum logic [6:0] {
        PH_HDR  = 7'b0000001,
        PH_CHDR = 7'b0000010,
        PH_FMT  = 7'b0000100,
        PH_SKIP = 7'b0001000,
        PH_PAD  = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_DONE = 7'b1000000
    } t_phase;

    // sequencer around the divider
    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_DIV  = 3'b010,
        SQ_RES  = 3'b100
    } t_seq;

    t_phase          r_phase, n_phase;
    logic [4:0]      r_bc, n_bc;
    logic [31:0]     r_tag, n_tag;
    logic [31:0]     r_rem, n_rem;
    logic [15:0]     r_fmt, n_fmt;
    logic [15:0]     r_cc, n_cc;
    logic [31:0]     r_rate, n_rate;
    logic [15:0]     r_bits, n_bits;
    logic [31:0]     r_asm, n_asm;
    logic [CIW-1:0]  r_ci, n_ci;
    logic signed [SW-1:0] r_sum, n_sum;
    logic            r_pad, n_pad;

    t_seq            r_seq, n_seq;
    logic [SW-1:0]   r_dq, n_dq;
    logic [CIW-1:0]  r_dr, n_dr;
    logic [CIW-1:0]  r_dd, n_dd;
    logic            r_dneg, n_dneg;
    logic            r_dfin, n_dfin;
    logic [DCW-1:0]  r_dcnt, n_dcnt;

    t_out            r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            out_free;
    logic            accept;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_seq == SQ_IDLE) && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // float to Q1.31, saturating, NaN to zero
    function automatic logic signed [31:0] f2q(input logic [31:0] x);
        logic [7:0]         e;
        logic [23:0]        m;
        logic signed [9:0]  sh;
        logic [32:0]        mag;
        logic [32:0]        neg;
        begin
            e   = x[30:23];
            m   = {1'b0, x[22:0]};
            mag = 33'd0;
            if (e == 8'd0) begin
                e = 8'd1;
            end else begin
                m[23] = 1'b1;
            end
            sh = $signed({2'b00, e}) - 10'sd119;
            if (x[30:23] == 8'hFF) begin
                mag = 33'h1_0000_0000 >> 1;
            end else if (sh >= 10'sd8) begin
                mag = 33'h0_8000_0000;
            end else if (sh >= 10'sd0) begin
                mag = {9'd0, m} << sh[2:0];
            end else if (sh <= -10'sd25) begin
                mag = 33'd0;
            end else begin
                mag = {9'd0, m >> 5'(-sh)};
            end
            neg = -mag;
            if (x[30:23] == 8'hFF && x[22:0] != 23'd0) begin
                f2q = 32'sd0;
            end else if (x[31]) begin
                f2q = $signed(neg[31:0]);
            end else if (mag > 33'h0_7FFF_FFFF) begin
                f2q = 32'sh7FFF_FFFF;
            end else begin
                f2q = $signed(mag[31:0]);
            end
        end
    endfunction

    always_comb begin
        logic               res;
        t_status            res_st;
        logic signed [31:0] smp;
        logic               chk_last;
        logic               two_b;
        logic [17:0]        fbytes;
        logic [31:0]        bsh;
        logic [CIW:0]       trial;
        logic [SW-1:0]      smag;

        n_phase = r_phase; n_bc = r_bc; n_tag = r_tag; n_rem = r_rem;
        n_fmt = r_fmt; n_cc = r_cc; n_rate = r_rate; n_bits = r_bits;
        n_asm = r_asm; n_ci = r_ci; n_sum = r_sum; n_pad = r_pad;
        n_seq = r_seq; n_dq = r_dq; n_dr = r_dr; n_dd = r_dd;
        n_dneg = r_dneg; n_dfin = r_dfin; n_dcnt = r_dcnt;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        res = 1'b0; res_st = ST_SAMPLE; chk_last = 1'b0;
        smp = 32'sd0; bsh = 32'd0; trial = '0; smag = '0;
        two_b  = (r_bits == 16'd16);
        fbytes = two_b ? {1'b0, r_cc, 1'b0} : {r_cc, 2'b00};

        unique case (r_seq)
            SQ_IDLE: begin
                if (accept) begin
                    if (i_in.first_byte) begin
                        n_phase = PH_HDR; n_bc = '0; n_tag = '0; n_rem = '0;
                        n_fmt = '0; n_cc = '0; n_rate = '0; n_bits = '0;
                        n_asm = '0; n_ci = '0; n_sum = '0; n_pad = 1'b0;
                    end
                    two_b  = (n_bits == 16'd16);
                    fbytes = two_b ? {1'b0, n_cc, 1'b0} : {n_cc, 2'b00};
                    unique case (n_phase)
                        PH_HDR: begin
                            chk_last = 1'b1;
                            if (n_bc < 5'd4 || n_bc >= 5'd8)
                                n_tag = {n_tag[23:0], i_in.file_byte};
                            if ((n_bc == 5'd3 && n_tag != TAG_RIFF) ||
                                (n_bc == 5'd11 && n_tag != TAG_WAVE)) begin
                                n_phase = PH_DONE; res = 1'b1; res_st = ST_BAD_HEADER;
                                chk_last = 1'b0;
                            end else begin
                                if (n_bc == 5'd3 || n_bc == 5'd11) n_tag = '0;
                                if (n_bc == 5'd11) begin
                                    n_phase = PH_CHDR; n_bc = '0;
                                end else begin
                                    n_bc = n_bc + 5'd1;
                                end
                            end
                        end
                        PH_CHDR: begin
                            chk_last = 1'b1;
                            if (n_bc < 5'd4) begin
                                n_tag = {n_tag[23:0], i_in.file_byte};
                                if (n_bc == 5'd0) n_rem = '0;
                            end else begin
                                bsh   = {24'd0, i_in.file_byte} << {n_bc[1:0], 3'b000};
                                n_rem = n_rem | bsh;
                            end
                            if (n_bc < 5'd7) begin
                                n_bc = n_bc + 5'd1;
                            end else begin
                                n_bc  = '0;
                                n_pad = n_rem[0];
                                if (n_tag == TAG_DATA) begin
                                    n_phase  = PH_DONE;
                                    chk_last = 1'b0;
                                    if (!(two_b || (n_bits == 16'd32 &&
                                          (n_fmt == FMT_PCM || n_fmt == FMT_FLOAT))) ||
                                        n_cc == 16'd0 ||
                                        n_cc > 16'(MAX_CHANNELS)) begin
                                        res = 1'b1; res_st = ST_UNSUPPORTED;
                                    end else if (n_rem < {14'd0, fbytes}) begin
                                        res = 1'b1; res_st = ST_NO_DATA;
                                    end else begin
                                        n_phase  = PH_DATA; chk_last = 1'b1;
                                        n_asm = '0; n_ci = '0; n_sum = '0;
                                    end
                                end else begin
                                    n_phase = (n_tag == TAG_FMT) ? PH_FMT : PH_SKIP;
                                    if (n_rem == 32'd0) begin
                                        n_phase = n_pad ? PH_PAD : PH_CHDR;
                                        n_tag = '0;
                                    end
                                end
                            end
                        end
                        PH_FMT, PH_SKIP: begin
                            chk_last = 1'b1;
                            if (n_phase == PH_FMT) begin
                                unique case (n_bc)
                                    5'd0:  n_fmt[7:0]    = i_in.file_byte;
                                    5'd1:  n_fmt[15:8]   = i_in.file_byte;
                                    5'd2:  n_cc[7:0]     = i_in.file_byte;
                                    5'd3:  n_cc[15:8]    = i_in.file_byte;
                                    5'd4:  n_rate[7:0]   = i_in.file_byte;
                                    5'd5:  n_rate[15:8]  = i_in.file_byte;
                                    5'd6:  n_rate[23:16] = i_in.file_byte;
                                    5'd7:  n_rate[31:24] = i_in.file_byte;
                                    5'd14: n_bits[7:0]   = i_in.file_byte;
                                    5'd15: n_bits[15:8]  = i_in.file_byte;
                                    default: ;
                                endcase
                                if (n_bc != 5'd31) n_bc = n_bc + 5'd1;
                            end
                            n_rem = n_rem - 32'd1;
                            if (n_rem == 32'd0) begin
                                n_phase = n_pad ? PH_PAD : PH_CHDR;
                                n_bc = '0; n_tag = '0;
                            end
                        end
                        PH_PAD: begin
                            chk_last = 1'b1;
                            n_pad = 1'b0; n_phase = PH_CHDR; n_bc = '0; n_tag = '0;
                        end
                        PH_DATA: begin
                            n_rem = n_rem - 32'd1;
                            bsh   = {24'd0, i_in.file_byte} << {n_bc[1:0], 3'b000};
                            n_asm = n_asm | bsh;
                            n_bc  = n_bc + 5'd1;
                            if (n_bc >= (two_b ? 5'd2 : 5'd4)) begin
                                if (two_b)
                                    smp = $signed({n_asm[15:0], 16'd0});
                                else if (n_fmt == FMT_FLOAT)
                                    smp = f2q(n_asm);
                                else
                                    smp = $signed(n_asm);
                                n_sum = n_sum + SW'(smp);
                                n_bc = '0; n_asm = '0;
                                n_ci = n_ci + CIW'(1);
                                if (16'(n_ci) >= n_cc) begin
                                    // frame complete: hand the sum to the divider
                                    smag   = n_sum[SW-1] ? SW'(-n_sum) : SW'(n_sum);
                                    n_dq   = smag;
                                    n_dr   = '0;
                                    n_dd   = n_cc[CIW-1:0];
                                    n_dneg = n_sum[SW-1];
                                    n_dfin = i_in.last_byte ||
                                             (n_rem < {14'd0, fbytes});
                                    n_dcnt = '0;
                                    n_seq  = SQ_DIV;
                                    n_sum  = '0; n_ci = '0;
                                    if (n_dfin) n_phase = PH_DONE;
                                end else if (i_in.last_byte) begin
                                    n_phase = PH_DONE; res = 1'b1; res_st = ST_NO_DATA;
                                end
                            end else if (i_in.last_byte) begin
                                n_phase = PH_DONE; res = 1'b1; res_st = ST_NO_DATA;
                            end
                        end
                        default: ;
                    endcase
                    if (chk_last && i_in.last_byte && n_phase != PH_DONE) begin
                        n_phase = PH_DONE; res = 1'b1; res_st = ST_NO_DATA;
                    end
                    if (res) begin
                        n_out.mono_sample = 32'sd0;
                        n_out.status      = res_st;
                        n_out.sample_rate = n_rate;
                        n_out.last_sample = 1'b0;
                        n_out_valid       = 1'b1;
                    end
                end
            end
            SQ_DIV: begin
                // one restoring step: quotient bits shift in at the bottom
                trial = {r_dr, r_dq[SW-1]};
                n_dq  = {r_dq[SW-2:0], 1'b0};
                if (trial >= {1'b0, r_dd}) begin
                    trial   = trial - {1'b0, r_dd};
                    n_dq[0] = 1'b1;
                end
                n_dr   = trial[CIW-1:0];
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(SW - 1)) n_seq = SQ_RES;
            end
            SQ_RES: begin
                if (out_free) begin
                    smag = r_dneg ? SW'(-r_dq) : r_dq;
                    n_out.mono_sample = $signed(smag[31:0]);
                    n_out.status      = ST_SAMPLE;
                    n_out.sample_rate = r_rate;
                    n_out.last_sample = r_dfin;
                    n_out_valid       = 1'b1;
                    n_seq             = SQ_IDLE;
                end
            end
            default: n_seq = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR; r_bc <= '0; r_tag <= '0; r_rem <= '0;
            r_fmt <= '0; r_cc <= '0; r_rate <= '0; r_bits <= '0;
            r_asm <= '0; r_ci <= '0; r_sum <= '0; r_pad <= 1'b0;
            r_seq <= SQ_IDLE; r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_bc <= n_bc; r_tag <= n_tag; r_rem <= n_rem;
            r_fmt <= n_fmt; r_cc <= n_cc; r_rate <= n_rate; r_bits <= n_bits;
            r_asm <= n_asm; r_ci <= n_ci; r_sum <= n_sum; r_pad <= n_pad;
            r_seq <= n_seq; r_out_valid <= n_out_valid;
        end
    end

    // divider and output payload
    always_ff @(posedge i_clk) begin
        r_dq <= n_dq; r_dr <= n_dr; r_dd <= n_dd; r_dneg <= n_dneg;
        r_dfin <= n_dfin; r_dcnt <= n_dcnt; r_out <= n_out;
    end

endmodule
